FILE: sv/code_length_body_message_parser_core_defines.svh
// assertion macros used by the parser core rtl
`ifndef CODE_LENGTH_BODY_MESSAGE_PARSER_CORE_DEFINES_SVH
`define CODE_LENGTH_BODY_MESSAGE_PARSER_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define CBMP_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("cbmp same-cycle check failed");
// next-cycle implication
`define CBMP_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("cbmp next-cycle check failed");
`else
`define CBMP_ASSERT_IMP(label, clk, rstn, ante, cons)
`define CBMP_ASSERT_NXT(label, clk, rstn, ante, cons)
`endif
`endif

FILE: sv/cbmp_pkg.sv
package cbmp_pkg;

    // input item kinds
    localparam logic KIND_DATA  = 1'b0;
    localparam logic KIND_CLEAR = 1'b1;

    // ascii codes used by the classifier
    localparam logic [7:0] CHAR_UNDERSCORE = 8'h5f;
    localparam logic [7:0] CHAR_SPACE      = 8'h20;
    localparam logic [7:0] CHAR_TAB        = 8'h09;
    localparam logic [7:0] CHAR_CR         = 8'h0d;
    localparam logic [7:0] CHAR_ZERO       = 8'h30;
    localparam logic [7:0] CHAR_NINE       = 8'h39;
    localparam logic [7:0] CHAR_UPPER_A    = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z    = 8'h5a;
    localparam logic [7:0] CHAR_LOWER_A    = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z    = 8'h7a;

    localparam int BODY_LENGTH_WIDTH = 32;

    typedef enum logic [6:0] {
        PH_BEFORE_CODE   = 7'b0000001,
        PH_CODE          = 7'b0000010,
        PH_BEFORE_LENGTH = 7'b0000100,
        PH_LENGTH        = 7'b0001000,
        PH_BEFORE_BODY   = 7'b0010000,
        PH_BODY          = 7'b0100000,
        PH_END           = 7'b1000000
    } phase_t;

    typedef enum logic [1:0] {
        ROLE_NONE = 2'd0,
        ROLE_CODE = 2'd1,
        ROLE_BODY = 2'd2,
        ROLE_TERM = 2'd3
    } role_t;

    typedef enum logic [1:0] {
        STAT_INCOMPLETE = 2'd0,
        STAT_COMPLETE   = 2'd1,
        STAT_ERROR      = 2'd2
    } status_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
        logic       chunk_last;
    } in_t;

    typedef struct packed {
        logic [7:0]                   out_byte;
        logic [1:0]                   byte_role;
        logic [1:0]                   status;
        logic [BODY_LENGTH_WIDTH-1:0] body_length;
        logic                         length_overflow;
        logic                         call_done;
    } out_t;

    // control state passed between the step logic and the state registers
    typedef struct packed {
        phase_t phase;
        logic   overflow;
    } ctrl_t;

endpackage

FILE: sv/cbmp_step.sv
module cbmp_step #(
    parameter int LENGTH_WIDTH = 32
) (
    input  cbmp_pkg::in_t             item_i,
    input  cbmp_pkg::ctrl_t           ctrl_i,
    input  logic [LENGTH_WIDTH-1:0]   length_i,
    input  logic [LENGTH_WIDTH-1:0]   count_i,
    output cbmp_pkg::ctrl_t           ctrl_o,
    output logic [LENGTH_WIDTH-1:0]   length_o,
    output logic [LENGTH_WIDTH-1:0]   count_o,
    output cbmp_pkg::out_t            result_o
);
    import cbmp_pkg::*;

    logic [7:0]              c;
    logic                    is_ws;
    logic                    is_digit;
    logic                    is_alpha;
    logic [LENGTH_WIDTH+3:0] times_ten;
    logic                    digit_sat;
    logic [LENGTH_WIDTH-1:0] length_digit;
    logic [LENGTH_WIDTH-1:0] count_inc;
    logic                    err;
    role_t                   role;
    status_t                 status;
    logic [63:0]             length_wide;

    assign c        = item_i.data_byte;
    assign is_ws    = (c == CHAR_SPACE) || (c >= CHAR_TAB && c <= CHAR_CR);
    assign is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    assign is_alpha = (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z)
                   || (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z);

    // length * 10 + digit, saturating when it leaves the register
    assign times_ten = {1'b0, length_i, 3'b000} + {3'b000, length_i, 1'b0}
                     + {{LENGTH_WIDTH{1'b0}}, c[3:0]};
    assign digit_sat    = |times_ten[LENGTH_WIDTH+3:LENGTH_WIDTH];
    assign length_digit = digit_sat ? {LENGTH_WIDTH{1'b1}} : times_ten[LENGTH_WIDTH-1:0];
    assign count_inc    = count_i + LENGTH_WIDTH'(1);

    always_comb begin
        ctrl_o   = ctrl_i;
        length_o = length_i;
        count_o  = count_i;
        role     = ROLE_NONE;
        status   = STAT_INCOMPLETE;
        err      = 1'b0;
        unique case (ctrl_i.phase) inside
            PH_BEFORE_CODE: begin
                if (is_ws) begin
                end else if (is_alpha) begin
                    ctrl_o.phase = PH_CODE;
                    role         = ROLE_CODE;
                end else begin
                    err = 1'b1;
                end
            end
            PH_CODE: begin
                if (is_alpha || is_digit || c == CHAR_UNDERSCORE) begin
                    role = ROLE_CODE;
                end else if (is_ws) begin
                    ctrl_o.phase = PH_BEFORE_LENGTH;
                    role         = ROLE_TERM;
                end else begin
                    err = 1'b1;
                end
            end
            PH_BEFORE_LENGTH: begin
                if (is_ws) begin
                end else if (is_digit) begin
                    ctrl_o.phase    = PH_LENGTH;
                    length_o        = length_digit;
                    ctrl_o.overflow = ctrl_i.overflow | digit_sat;
                end else begin
                    err = 1'b1;
                end
            end
            PH_LENGTH: begin
                if (is_digit) begin
                    length_o        = length_digit;
                    ctrl_o.overflow = ctrl_i.overflow | digit_sat;
                end else if (is_ws) begin
                    if (length_i == '0) begin
                        ctrl_o.phase = PH_END;
                        status       = STAT_COMPLETE;
                    end else begin
                        ctrl_o.phase = PH_BEFORE_BODY;
                    end
                end else begin
                    err = 1'b1;
                end
            end
            PH_BEFORE_BODY, PH_BODY: begin
                if (length_i == '0) begin
                    ctrl_o.phase = PH_END;
                    status       = STAT_COMPLETE;
                end else if (ctrl_i.phase == PH_BEFORE_BODY && is_ws) begin
                end else begin
                    role    = ROLE_BODY;
                    count_o = count_inc;
                    if (count_inc >= length_i) begin
                        ctrl_o.phase = PH_END;
                        status       = STAT_COMPLETE;
                    end else begin
                        ctrl_o.phase = PH_BODY;
                    end
                end
            end
            default: begin
                // completed, and any unreachable code, holds until a clear
                status = STAT_COMPLETE;
            end
        endcase
        if (err || item_i.kind == KIND_CLEAR) begin
            ctrl_o.phase    = PH_BEFORE_CODE;
            ctrl_o.overflow = 1'b0;
            length_o        = '0;
            count_o         = '0;
            role            = ROLE_NONE;
            status          = err && item_i.kind == KIND_DATA ? STAT_ERROR : STAT_INCOMPLETE;
        end
    end

    assign length_wide = 64'(length_o);

    always_comb begin
        result_o.out_byte        = c;
        result_o.byte_role       = role;
        result_o.status          = status;
        result_o.body_length     = length_wide[BODY_LENGTH_WIDTH-1:0];
        result_o.length_overflow = ctrl_o.overflow;
        result_o.call_done       = item_i.chunk_last;
    end

endmodule

FILE: sv/code_length_body_message_parser_core.sv
// byte-serial parser for "code length body" messages
// s_ channel: one byte a transfer; kind selects parse (data) or clear,
// chunk_last marks the end of a caller's buffer and comes back as call_done
// m_ channel: exactly one result per input transfer, in order: the byte echo,
// its role (code char, code terminator, body byte, other), message status
// and the length parsed so far with a sticky saturation flag
// path: a byte accepted at a clock edge lands in the input register, then
// the parse step runs against the parser state and the result register
// loads its result once the result slot is free or draining, which raises
// m_valid; the result transfers when m_ready is high
// throughput: one byte per cycle while m_ready stays high; the single-step
// parse logic between the input and result registers sets that rate
// reset (aresetn low at a clock edge): both registers empty, parser back to
// waiting for a code word, length, body count and overflow flag zero
// stalls: while m_ready is low the result holds, the input register can
// still take one more transfer, then s_ready drops until the result drains
`include "code_length_body_message_parser_core_defines.svh"
module code_length_body_message_parser_core #(
    parameter int LENGTH_WIDTH = 32
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  cbmp_pkg::in_t   s_payload,
    output logic            m_valid,
    input  logic            m_ready,
    output cbmp_pkg::out_t  m_payload
);
    import cbmp_pkg::*;

    // input stage
    in_t                     in_reg;
    logic                    in_valid_reg;

    // parser state
    ctrl_t                   ctrl_reg;
    ctrl_t                   ctrl_next;
    logic [LENGTH_WIDTH-1:0] length_reg;
    logic [LENGTH_WIDTH-1:0] length_next;
    logic [LENGTH_WIDTH-1:0] count_reg;
    logic [LENGTH_WIDTH-1:0] count_next;

    // result stage
    out_t                    out_reg;
    out_t                    out_next;
    logic                    out_valid_reg;

    logic                    advance;

    // the buffered byte moves on whenever the result slot is free or draining
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    cbmp_step #(
        .LENGTH_WIDTH(LENGTH_WIDTH)
    ) u_step (
        .item_i   (in_reg),
        .ctrl_i   (ctrl_reg),
        .length_i (length_reg),
        .count_i  (count_reg),
        .ctrl_o   (ctrl_next),
        .length_o (length_next),
        .count_o  (count_next),
        .result_o (out_next)
    );

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_payload;
        end
    end

    // parser state commits only when the step's result is taken into the slot
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_reg.phase    <= PH_BEFORE_CODE;
            ctrl_reg.overflow <= 1'b0;
            length_reg        <= '0;
            count_reg         <= '0;
        end else if (advance) begin
            ctrl_reg   <= ctrl_next;
            length_reg <= length_next;
            count_reg  <= count_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= out_next;
        end
    end

    assign m_valid   = out_valid_reg;
    assign m_payload = out_reg;

    // an error result always reports a cleared length
    `CBMP_ASSERT_IMP(a_err_cleared, aclk, aresetn, m_valid && m_payload.status == STAT_ERROR, m_payload.body_length == '0 && !m_payload.length_overflow)
    // the overflow flag implies a saturated length
    `CBMP_ASSERT_IMP(a_ovf_sat, aclk, aresetn, ctrl_reg.overflow, length_reg == {LENGTH_WIDTH{1'b1}})
    // the body count never runs past the length
    `CBMP_ASSERT_IMP(a_count_bound, aclk, aresetn, 1'b1, count_reg <= length_reg)
    // waiting for a code word means nothing has accumulated
    `CBMP_ASSERT_IMP(a_idle_clean, aclk, aresetn, ctrl_reg.phase == PH_BEFORE_CODE, length_reg == '0 && count_reg == '0 && !ctrl_reg.overflow)
    // a clear that moves through resets the parser
    `CBMP_ASSERT_NXT(a_clear, aclk, aresetn, advance && in_reg.kind == KIND_CLEAR, ctrl_reg.phase == PH_BEFORE_CODE)

endmodule

FILE: sim/parse_scoreboard_pkg.sv
`timescale 1ns / 1ps

package parse_scoreboard_pkg;
    import cbmp_pkg::*;

    class parse_scoreboard;
        // parser state as the block should hold it
        phase_t                       phase;
        logic [BODY_LENGTH_WIDTH-1:0] length_acc;
        logic [BODY_LENGTH_WIDTH-1:0] body_seen;
        logic                         sat_flag;

        out_t byte_results_due[$];

        int mismatches;
        int accepted;
        int checked;
        int completes;
        int syntax_errors;
        int saturations;

        function new();
            restart();
            mismatches    = 0;
            accepted      = 0;
            checked       = 0;
            completes     = 0;
            syntax_errors = 0;
            saturations   = 0;
        endfunction

        function void restart();
            phase      = PH_BEFORE_CODE;
            length_acc = '0;
            body_seen  = '0;
            sat_flag   = 1'b0;
        endfunction

        function bit is_ws(logic [7:0] c);
            return (c == CHAR_SPACE) || (c >= CHAR_TAB && c <= CHAR_CR);
        endfunction

        function bit is_digit(logic [7:0] c);
            return c >= CHAR_ZERO && c <= CHAR_NINE;
        endfunction

        function bit is_alpha(logic [7:0] c);
            return (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) ||
                   (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z);
        endfunction

        // decimal accumulate, pinned at all ones once it would wrap
        function void add_digit(logic [7:0] c);
            logic [63:0] d;
            logic [63:0] top;
            d   = 64'(c - CHAR_ZERO);
            top = 64'({BODY_LENGTH_WIDTH{1'b1}});
            if (64'(length_acc) > (top - d) / 10) begin
                if (!sat_flag)
                    saturations++;
                length_acc = top[BODY_LENGTH_WIDTH-1:0];
                sat_flag   = 1'b1;
            end else begin
                length_acc = BODY_LENGTH_WIDTH'(64'(length_acc) * 10 + d);
            end
        endfunction

        // one parse step: advances the state and returns the result it causes
        function out_t parse_byte(in_t it);
            out_t    r;
            role_t   role;
            status_t stat;
            bit      bad;
            logic [7:0] c;
            r    = '0;
            role = ROLE_NONE;
            stat = STAT_INCOMPLETE;
            bad  = 1'b0;
            c    = it.data_byte;
            if (it.kind == KIND_CLEAR) begin
                restart();
            end else begin
                case (phase)
                    PH_BEFORE_CODE: begin
                        if (is_alpha(c)) begin
                            phase = PH_CODE;
                            role  = ROLE_CODE;
                        end else if (!is_ws(c)) begin
                            bad = 1'b1;
                        end
                    end
                    PH_CODE: begin
                        if (is_alpha(c) || is_digit(c) || c == CHAR_UNDERSCORE) begin
                            role = ROLE_CODE;
                        end else if (is_ws(c)) begin
                            phase = PH_BEFORE_LENGTH;
                            role  = ROLE_TERM;
                        end else begin
                            bad = 1'b1;
                        end
                    end
                    PH_BEFORE_LENGTH: begin
                        if (is_digit(c)) begin
                            phase = PH_LENGTH;
                            add_digit(c);
                        end else if (!is_ws(c)) begin
                            bad = 1'b1;
                        end
                    end
                    PH_LENGTH: begin
                        if (is_digit(c)) begin
                            add_digit(c);
                        end else if (is_ws(c)) begin
                            if (length_acc == 0) begin
                                phase = PH_END;
                                stat  = STAT_COMPLETE;
                            end else begin
                                phase = PH_BEFORE_BODY;
                            end
                        end else begin
                            bad = 1'b1;
                        end
                    end
                    PH_BEFORE_BODY, PH_BODY: begin
                        if (length_acc == 0) begin
                            phase = PH_END;
                            stat  = STAT_COMPLETE;
                        end else if (!(phase == PH_BEFORE_BODY && is_ws(c))) begin
                            phase = PH_BODY;
                            role  = ROLE_BODY;
                            body_seen++;
                            if (body_seen >= length_acc) begin
                                phase = PH_END;
                                stat  = STAT_COMPLETE;
                            end
                        end
                    end
                    default: begin
                        stat = STAT_COMPLETE;
                    end
                endcase
                if (bad) begin
                    restart();
                    role = ROLE_NONE;
                    stat = STAT_ERROR;
                end
            end
            r.out_byte        = c;
            r.byte_role       = role;
            r.status          = stat;
            r.body_length     = length_acc;
            r.length_overflow = sat_flag;
            r.call_done       = it.chunk_last;
            return r;
        endfunction

        function void note_input(in_t it);
            out_t   r;
            phase_t was;
            was = phase;
            r   = parse_byte(it);
            accepted++;
            if (r.status == STAT_ERROR)
                syntax_errors++;
            // a message completes on the byte that enters the end phase
            if (r.status == STAT_COMPLETE && was != PH_END)
                completes++;
            byte_results_due.push_back(r);
        endfunction

        function void check_result(out_t got);
            out_t want;
            checked++;
            if (byte_results_due.size() == 0) begin
                $error("result with nothing pending: %p", got);
                mismatches++;
                return;
            end
            want = byte_results_due.pop_front();
            if (got.out_byte !== want.out_byte) begin
                $error("out_byte expected %0h actual %0h", want.out_byte, got.out_byte);
                mismatches++;
            end
            if (got.byte_role !== want.byte_role) begin
                $error("byte_role expected %0d actual %0d", want.byte_role, got.byte_role);
                mismatches++;
            end
            if (got.status !== want.status) begin
                $error("status expected %0d actual %0d", want.status, got.status);
                mismatches++;
            end
            if (got.body_length !== want.body_length) begin
                $error("body_length expected %0d actual %0d",
                       want.body_length, got.body_length);
                mismatches++;
            end
            if (got.length_overflow !== want.length_overflow) begin
                $error("length_overflow expected %0b actual %0b",
                       want.length_overflow, got.length_overflow);
                mismatches++;
            end
            if (got.call_done !== want.call_done) begin
                $error("call_done expected %0b actual %0b", want.call_done, got.call_done);
                mismatches++;
            end
        endfunction

        function int pending();
            return byte_results_due.size();
        endfunction
    endclass

endpackage

FILE: sim/tb_code_length_body_message_parser_core.sv
`timescale 1ns / 1ps

module tb_code_length_body_message_parser_core;
    import cbmp_pkg::*;
    import parse_scoreboard_pkg::*;

    localparam int RANDOM_ITEMS   = 900;
    localparam int LONG_HOLD      = 200;  // receiver back-pressure stretch, cycles
    localparam int LONG_HOLD_AT   = 300;  // result count that triggers it
    localparam int DRAIN_CYCLES   = 20;   // quiet margin after the last expected result
    localparam int WATCHDOG_NS    = 4_000_000;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    in_t  s_payload;
    logic m_valid;
    logic m_ready;
    out_t m_payload;

    parse_scoreboard sb;
    in_t             stim_q[$];
    int              quiet_left[2];
    int              nres;

    code_length_body_message_parser_core DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    initial aclk = 1'b0;
    always #6 aclk = ~aclk;

    // wait draw for one side (0 sender, 1 receiver); now and then a quiet
    // stretch with no idling at all so back-to-back transfers happen too
    function automatic int draw_wait(int side);
        if (quiet_left[side] > 0) begin
            quiet_left[side]--;
            return 0;
        end
        if ($urandom_range(0, 24) == 0) begin
            quiet_left[side] = $urandom_range(20, 40);
            return 0;
        end
        return $urandom_range(0, 15);
    endfunction

    // ---------------------------------------------------------------------
    // stimulus building
    // ---------------------------------------------------------------------
    task automatic push_item(logic kind, logic [7:0] b, logic last);
        in_t it;
        it.kind       = kind;
        it.data_byte  = b;
        it.chunk_last = last;
        stim_q.push_back(it);
    endtask

    // text as data bytes, chunk boundary on the final byte
    task automatic push_text(string s);
        for (int i = 0; i < s.len(); i++)
            push_item(KIND_DATA, s[i], i == s.len() - 1);
    endtask

    function automatic logic [7:0] ws_char();
        int r;
        r = $urandom_range(0, 5);
        return (r == 5) ? CHAR_SPACE : CHAR_TAB + 8'(r);
    endfunction

    function automatic logic [7:0] alpha_char();
        int r;
        r = $urandom_range(0, 51);
        return (r < 26) ? CHAR_UPPER_A + 8'(r) : CHAR_LOWER_A + 8'(r - 26);
    endfunction

    function automatic logic [7:0] code_char();
        int r;
        r = $urandom_range(0, 62);
        if (r < 52)
            return alpha_char();
        if (r < 62)
            return CHAR_ZERO + 8'(r - 52);
        return CHAR_UNDERSCORE;
    endfunction

    function automatic logic rand_last();
        return $urandom_range(0, 3) == 0;
    endfunction

    // one message led by a clear; mostly well formed, sometimes truncated
    // or hit by one corrupted byte, occasionally with a saturating length
    task automatic add_message();
        logic [7:0] msg[$];
        logic [7:0] b;
        string      digits;
        int         n;
        int         ndig;
        int         nbody;
        repeat ($urandom_range(0, 2)) msg.push_back(ws_char());
        msg.push_back(alpha_char());
        repeat ($urandom_range(0, 5)) msg.push_back(code_char());
        repeat ($urandom_range(1, 2)) msg.push_back(ws_char());
        if ($urandom_range(0, 7) == 0) begin
            // ten to twelve digits: large, often past the 32-bit ceiling
            ndig = $urandom_range(10, 12);
            msg.push_back(CHAR_ZERO + 8'($urandom_range(1, 9)));
            repeat (ndig - 1) msg.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
            nbody = $urandom_range(0, 30);
        end else begin
            n = $urandom_range(0, 20);
            if ($urandom_range(0, 5) == 0)
                msg.push_back(CHAR_ZERO);  // leading zero
            digits = $sformatf("%0d", n);
            for (int i = 0; i < digits.len(); i++)
                msg.push_back(digits[i]);
            nbody = n;
            if (n > 0 && $urandom_range(0, 7) == 0)
                nbody = $urandom_range(0, n - 1);
        end
        repeat ($urandom_range(1, 2)) msg.push_back(ws_char());
        for (int i = 0; i < nbody; i++) begin
            b = 8'($urandom_range(0, 255));
            // whitespace ahead of the body is skipped, keep the first byte solid
            if (i == 0 && sb.is_ws(b))
                b[6] = 1'b1;
            msg.push_back(b);
        end
        repeat ($urandom_range(0, 2)) msg.push_back(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 5) == 0)
            msg[$urandom_range(0, msg.size() - 1)] = 8'($urandom_range(0, 255));
        push_item(KIND_CLEAR, 8'($urandom_range(0, 255)), rand_last());
        foreach (msg[i])
            push_item(KIND_DATA, msg[i], rand_last());
    endtask

    task automatic build_stimulus();
        int directed;
        // clear with every data bit high
        push_item(KIND_CLEAR, 8'hff, 1'b1);
        // zero-length message: leading space, code with underscore and digit,
        // tab ends the code, carriage return after the length completes it
        push_item(KIND_DATA, CHAR_SPACE, 1'b0);
        push_text("A_9");
        push_item(KIND_DATA, CHAR_TAB, 1'b0);
        push_item(KIND_DATA, CHAR_ZERO, 1'b0);
        push_item(KIND_DATA, CHAR_CR, 1'b1);
        // ignored after completion
        push_text("z");
        push_item(KIND_CLEAR, 8'h00, 1'b0);
        // two-byte body with extra whitespace ahead of it and extreme bytes
        push_text("q 2  ");
        push_item(KIND_DATA, 8'hff, 1'b0);
        push_item(KIND_DATA, 8'h00, 1'b1);
        push_item(KIND_CLEAR, 8'h00, 1'b0);
        // syntax errors in each phase that can raise one; each one clears the parser
        push_text("1");
        push_item(KIND_DATA, 8'h80, 1'b1);
        push_text("Z-");
        push_text("b x");
        push_text("c 5!");
        directed = stim_q.size();

        while (stim_q.size() < directed + RANDOM_ITEMS) begin
            if ($urandom_range(0, 9) == 0) begin
                // raw noise, clears included
                repeat ($urandom_range(1, 4))
                    push_item($urandom_range(0, 3) == 0, 8'($urandom_range(0, 255)),
                              rand_last());
            end else begin
                add_message();
            end
        end
    endtask

    // ---------------------------------------------------------------------
    // drivers
    // ---------------------------------------------------------------------
    // sender: valid goes up at a falling edge and stays up with the same
    // payload until the transfer happens at a rising edge
    task automatic send_stream();
        int gap;
        @(negedge aclk);
        foreach (stim_q[i]) begin
            gap = draw_wait(0);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            s_valid   <= 1'b1;
            s_payload <= stim_q[i];
            do @(posedge aclk); while (!s_ready);
            sb.note_input(stim_q[i]);
            @(negedge aclk);
        end
        s_valid <= 1'b0;
    endtask

    // receiver: random stalls, plus one long hold so the block backs up
    // and drops s_ready while the sender keeps offering
    task automatic drain_results();
        int hold;
        @(negedge aclk);
        forever begin
            hold = (nres == LONG_HOLD_AT) ? LONG_HOLD : draw_wait(1);
            if (hold > 0) begin
                m_ready <= 1'b0;
                repeat (hold) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            sb.check_result(m_payload);
            nres++;
            @(negedge aclk);
        end
    endtask

    // ---------------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------------
    initial begin
        // every input known from time zero
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_payload     = '0;
        m_ready       = 1'b0;
        quiet_left[0] = 0;
        quiet_left[1] = 0;
        nres          = 0;
        sb            = new();
        build_stimulus();

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        fork
            drain_results();
        join_none
        send_stream();

        // all transfers in; wait for the last results, then a quiet margin
        // in which any stray result would be flagged
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("run covered %0d input transfers and %0d checked results",
                 sb.accepted, sb.checked);
        $display("seen: %0d completed messages, %0d syntax errors, %0d length saturations",
                 sb.completes, sb.syntax_errors, sb.saturations);
        if (sb.mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // hang guard, far beyond the slowest legal run
    initial begin
        #(WATCHDOG_NS);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
